// ===== rtl/core/sst_pkg.sv =====
// Shared constants, codes and types for the session slot table.
package sst_pkg;

   localparam int SLOTS  = 64;
   localparam int SLOT_W = 6;
   localparam int CNT_W  = 7;
   localparam int SEQ_W  = 32;
   localparam int ID_W   = 32;
   localparam int HOLD_W = 16;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [HOLD_W-1:0] HOLDOFF_RESET = HOLD_W'(2000);

   typedef enum logic [2:0] {
      OP_GET      = 3'd0,
      OP_FREE     = 3'd1,
      OP_COMPLETE = 3'd2,
      OP_RECALL   = 3'd3,
      OP_BAD_SLOT = 3'd4,
      OP_TICK     = 3'd5,
      OP_REINIT   = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NO_SLOT  = 2'd1,
      STAT_BAD_ZERO = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_ACQ,
      S_SCAN,
      S_SEQ,
      S_BUMP,
      S_WALK,
      S_DONE
   } state_type;

   // sequence RAM command: read and write never share a cycle
   typedef struct packed {
      logic              clear;
      logic              rd_en;
      logic              wr_en;
      logic [SLOT_W-1:0] addr;
      logic [SEQ_W-1:0]  wr_data;
   } seq_cmd_type;

   localparam int CSR_HOLDOFF = 0;

   // limit for a target highest slot id, target clamped to SLOTS-1
   function automatic logic [CNT_W-1:0] limit_for(input logic [ID_W-1:0] target);
      logic [CNT_W-1:0] lim;
      if (target >= ID_W'(SLOTS - 1)) begin
         lim = CNT_W'(SLOTS);
      end else begin
         lim = CNT_W'(target[SLOT_W-1:0]) + CNT_W'(1);
      end
      return lim;
   endfunction

endpackage

// ===== rtl/core/sst_if.sv =====
// Request and response channel interfaces of the session slot table.
interface sst_req_if;
   import sst_pkg::*;
   logic                valid;
   logic                ready;
   logic [2:0]          op;
   logic [ID_W-1:0]     slot_id;
   logic [ID_W-1:0]     target_highest;

   modport source (output valid, op, slot_id, target_highest, input ready);
   modport sink   (input valid, op, slot_id, target_highest, output ready);
endinterface

interface sst_rsp_if;
   import sst_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [SLOT_W-1:0]   granted_slot;
   logic [SEQ_W-1:0]    granted_seq;
   logic [SLOT_W-1:0]   highest_in_use;
   logic [CNT_W-1:0]    slot_limit_now;
   logic [CNT_W-1:0]    used_count_now;

   modport source (output valid, status, granted_slot, granted_seq, highest_in_use,
                   slot_limit_now, used_count_now, input ready);
   modport sink   (input valid, status, granted_slot, granted_seq, highest_in_use,
                   slot_limit_now, used_count_now, output ready);
endinterface

// ===== rtl/core/sst_seq_ram.sv =====
// Per-slot sequence number RAM; entries never written since clear read as one.
module sst_seq_ram (
   input  logic                      clock,
   input  logic                      reset,
   input  sst_pkg::seq_cmd_type      cmd,
   output logic [sst_pkg::SEQ_W-1:0] rd_data
);
   import sst_pkg::*;

   logic [SEQ_W-1:0] mem [SLOTS];
   logic [SLOTS-1:0] written_ff;
   logic [SLOTS-1:0] written_in;
   logic [SEQ_W-1:0] rd_data_ff;

   always_comb begin
      written_in = written_ff;
      if (cmd.clear) begin
         written_in = '0;
      end else if (cmd.wr_en) begin
         written_in[cmd.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= written_ff[cmd.addr] ? mem[cmd.addr] : SEQ_W'(1);
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/session_slot_table.sv =====
// Top level of the session slot table: sequencer, slot flags and CSR port.
//  - req_ch carries one word per operation (op, slot_id, target_highest); ready is high
//    only while the sequencer is idle, so one operation is worked at a time.
//  - rsp_ch returns one word per operation: status, granted slot and sequence, highest
//    slot in use, slot limit and used count after the operation.
//  - Steps after the accepting cycle: an execute step, then a done step that loads the
//    response register; tick, recall, reinit, bad slot zero and a free or complete with
//    no walk or bump need no more. A complete in range reads, then bumps the sequence
//    RAM. A get checks the limit, scans one flag per cycle by the scan counter and
//    reads the sequence of the slot it takes. A free at the highest mark walks it down.
//    A bad-slot report of a nonzero slot shrinks the limit, then is a free and a get.
//  - Longest operations: a full scan, or a walk and a scan that together span the table.
//    The next word is taken in the cycle after the response loads.
//  - The response register parts the two sides: a new request is accepted while the
//    last response waits; a finished operation holds in its final step until
//    rsp_ch.ready frees the register.
//  - Reset (synchronous, active high) clears all slots, sets the limit to 64, sequence
//    numbers to one, stops the hold-off timer and loads holdoff_ticks with 2000.
//    Reinit does the same but keeps holdoff_ticks.
//  - CSR: holdoff_ticks at byte address 0, written on psel&penable&pwrite&pready.
module session_slot_table (
   input  logic                       clock,
   input  logic                       reset,
   sst_req_if.sink                    req_ch,
   sst_rsp_if.source                  rsp_ch,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [sst_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [sst_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [sst_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);
   import sst_pkg::*;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [ID_W-1:0]    target_ff, target_in;
   logic [SLOTS-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   limit_ff, limit_in;
   logic [SLOT_W-1:0]  mark_ff, mark_in;
   logic [HOLD_W-1:0]  hold_ff, hold_in;
   logic [HOLD_W-1:0]  ticks_ff, ticks_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   status_type         status_ff, status_in;
   logic [SLOT_W-1:0]  gslot_ff, gslot_in;
   logic [SEQ_W-1:0]   gseq_ff, gseq_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [SEQ_W-1:0]   rsp_seq_ff, rsp_seq_in;
   logic [SLOT_W-1:0]  rsp_mark_ff, rsp_mark_in;
   logic [CNT_W-1:0]   rsp_limit_ff, rsp_limit_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;

   seq_cmd_type        seq_cmd;
   logic [SEQ_W-1:0]   seq_rd_data;

   logic               req_take;
   logic               rsp_free;
   logic               id_in_range;
   logic               id_is_zero;
   logic               id_hits_mark;
   logic [SLOT_W-1:0]  id_slot;
   logic               walk_more;
   logic               scan_last;
   logic               csr_write;

   sst_seq_ram u_seq_ram (
      .clock   (clock),
      .reset   (reset),
      .cmd     (seq_cmd),
      .rd_data (seq_rd_data)
   );

   assign req_take     = req_ch.valid && (state_ff == S_IDLE);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign id_slot      = id_ff[SLOT_W-1:0];
   assign id_in_range  = id_ff < ID_W'(SLOTS);
   assign id_is_zero   = id_ff == '0;
   assign id_hits_mark = id_ff == ID_W'(mark_ff);
   // mark walks down past free slots, stops at zero
   assign walk_more    = (mark_ff != '0) && !used_ff[mark_ff];
   assign scan_last    = (CNT_W'(idx_ff) + CNT_W'(1)) >= limit_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) state_in = S_EXEC;
         end
         S_EXEC: begin
            case (op_ff)
               OP_GET:      state_in = S_ACQ;
               OP_FREE:     state_in = id_hits_mark ? S_WALK : S_DONE;
               OP_COMPLETE: state_in = id_in_range ? S_BUMP : S_DONE;
               OP_BAD_SLOT: begin
                  if (id_is_zero)        state_in = S_DONE;
                  else if (id_hits_mark) state_in = S_WALK;
                  else                   state_in = S_ACQ;
               end
               default:     state_in = S_DONE;
            endcase
         end
         S_WALK: begin
            if (!walk_more) state_in = (op_ff == OP_BAD_SLOT) ? S_ACQ : S_DONE;
         end
         S_ACQ: begin
            state_in = (count_ff >= limit_ff) ? S_DONE : S_SCAN;
         end
         S_SCAN: begin
            if (!used_ff[idx_ff])  state_in = S_SEQ;
            else if (scan_last)    state_in = S_DONE;
         end
         S_SEQ:  state_in = S_DONE;
         S_BUMP: state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in      = op_ff;
      id_in      = id_ff;
      target_in  = target_ff;
      used_in    = used_ff;
      count_in   = count_ff;
      limit_in   = limit_ff;
      mark_in    = mark_ff;
      hold_in    = hold_ff;
      idx_in     = idx_ff;
      status_in  = status_ff;
      gslot_in   = gslot_ff;
      gseq_in    = gseq_ff;
      seq_cmd    = '{clear: 1'b0, rd_en: 1'b0, wr_en: 1'b0, addr: id_slot,
                     wr_data: seq_rd_data + SEQ_W'(1)};

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_mark_in   = rsp_mark_ff;
      rsp_limit_in  = rsp_limit_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in     = op_type'(req_ch.op);
               id_in     = req_ch.slot_id;
               target_in = req_ch.target_highest;
               status_in = STAT_OK;
               gslot_in  = '0;
               gseq_in   = '0;
            end
         end
         S_EXEC: begin
            case (op_ff)
               OP_FREE: begin
                  if (id_in_range && used_ff[id_slot]) begin
                     used_in[id_slot] = 1'b0;
                     count_in         = count_ff - CNT_W'(1);
                  end
               end
               OP_COMPLETE: begin
                  seq_cmd.rd_en = id_in_range;
                  if (hold_ff == '0) limit_in = limit_for(target_ff);
               end
               OP_RECALL: begin
                  limit_in = limit_for(target_ff);
                  hold_in  = ticks_ff;
               end
               OP_BAD_SLOT: begin
                  if (id_is_zero) begin
                     status_in = STAT_BAD_ZERO;
                  end else begin
                     // shrink so the bad slot falls outside the limit
                     if (ID_W'(limit_ff) > id_ff) begin
                        limit_in = limit_for(id_ff - ID_W'(1));
                        hold_in  = ticks_ff;
                     end
                     if (id_in_range && used_ff[id_slot]) begin
                        used_in[id_slot] = 1'b0;
                        count_in         = count_ff - CNT_W'(1);
                     end
                  end
               end
               OP_TICK: begin
                  if (hold_ff != '0) hold_in = hold_ff - HOLD_W'(1);
               end
               OP_REINIT: begin
                  used_in       = '0;
                  count_in      = '0;
                  mark_in       = '0;
                  hold_in       = '0;
                  limit_in      = CNT_W'(SLOTS);
                  seq_cmd.clear = 1'b1;
               end
               default: ;
            endcase
         end
         S_WALK: begin
            if (walk_more) mark_in = mark_ff - SLOT_W'(1);
         end
         S_ACQ: begin
            if (count_ff >= limit_ff) status_in = STAT_NO_SLOT;
            idx_in = '0;
         end
         S_SCAN: begin
            if (!used_ff[idx_ff]) begin
               used_in[idx_ff] = 1'b1;
               count_in        = count_ff + CNT_W'(1);
               if (idx_ff > mark_ff) mark_in = idx_ff;
               gslot_in        = idx_ff;
               seq_cmd.rd_en   = 1'b1;
               seq_cmd.addr    = idx_ff;
            end else if (scan_last) begin
               status_in = STAT_NO_SLOT;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         S_SEQ: begin
            gseq_in = seq_rd_data;
         end
         S_BUMP: begin
            seq_cmd.wr_en = 1'b1;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in   = gslot_ff;
               rsp_seq_in    = gseq_ff;
               rsp_mark_in   = mark_ff;
               rsp_limit_in  = limit_ff;
               rsp_count_in  = count_ff;
            end
         end
         default: ;
      endcase
   end

   // CSR port
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign ticks_in   = (csr_write && (csr_paddr[CSR_AW-1] == 1'b0))
                       ? csr_pwdata[HOLD_W-1:0] : ticks_ff;
   assign csr_prdata = (csr_paddr[CSR_AW-1] == 1'b0)
                       ? CSR_DW'(ticks_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         count_ff     <= '0;
         limit_ff     <= CNT_W'(SLOTS);
         mark_ff      <= '0;
         hold_ff      <= '0;
         ticks_ff     <= HOLDOFF_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         mark_ff      <= mark_in;
         hold_ff      <= hold_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      target_ff     <= target_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      gslot_ff      <= gslot_in;
      gseq_ff       <= gseq_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_mark_ff   <= rsp_mark_in;
      rsp_limit_ff  <= rsp_limit_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.granted_slot   = rsp_slot_ff;
   assign rsp_ch.granted_seq    = rsp_seq_ff;
   assign rsp_ch.highest_in_use = rsp_mark_ff;
   assign rsp_ch.slot_limit_now = rsp_limit_ff;
   assign rsp_ch.used_count_now = rsp_count_ff;

endmodule
